/* sv/ordered_list_insert_delete_core_assert.svh */
// Assertion macros for the list core's datapath (olid_dp).
// Depends on nothing; each macro is empty when SYNTHESIS is defined.
`ifndef ORDERED_LIST_INSERT_DELETE_CORE_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Expression must never hold outside reset.
`define OLID_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define OLID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define OLID_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`define OLID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/olid_pkg.sv */
// Package for the ordered list core: operation codes, FSM state type,
// and the command/status structs between controller and datapath.
package olid_pkg;

  localparam int FUNC_W = 2;
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;

  localparam logic [FUNC_W-1:0] FUNC_FRONT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BACK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LIST = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic accept;      // latch request and apply insert or remove setup
    logic step;        // read next list element and emit it
    logic emit_empty;  // emit the single empty-list beat
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;    // list holds nothing
    logic at_last;     // current index is the final element
  } sts_t;

endpackage

/* sv/olid_ctrl.sv */
// Controller FSM for the ordered list core: sequences accept, listing and
// the final write-back cycle. Depends on olid_pkg.
module olid_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  olid_pkg::sts_t sts,
  output olid_pkg::cmd_t cmd,
  output logic          busy
);

  olid_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olid_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      olid_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = olid_pkg::ST_LIST;
        end
      end
      olid_pkg::ST_LIST: begin
        if (sts.cnt_zero) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = olid_pkg::ST_IDLE;
        end else begin
          cmd.step = 1'b1;
          if (sts.at_last) begin
            state_nxt = olid_pkg::ST_DONE;
          end
        end
      end
      olid_pkg::ST_DONE: begin
        // let the last shift write land before the next request
        state_nxt = olid_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = olid_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/olid_dp.sv */
// Datapath for the ordered list core: circular element memory, head and
// count, listing index and output beat registers. Depends on olid_pkg.
`include "ordered_list_insert_delete_core_assert.svh"
module olid_dp #(
  parameter int DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  olid_pkg::cmd_t                cmd,
  output olid_pkg::sts_t                sts,
  input  logic [olid_pkg::FUNC_W-1:0]   in_func,
  input  logic signed [olid_pkg::DATA_W-1:0] in_value,
  input  logic [olid_pkg::POS_W-1:0]    in_position,
  output logic                          out_valid,
  output logic signed [olid_pkg::DATA_W-1:0] out_element,
  output logic                          out_last,
  output logic                          out_empty_res,
  output logic                          out_dropped
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [olid_pkg::DATA_W-1:0] mem [DEPTH];

  logic [AW-1:0]              head_r, head_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic [olid_pkg::POS_W-1:0] pos_r;
  logic                       rm_r, drop_r;
  logic [olid_pkg::DATA_W-1:0] rd_r;
  logic                       ov_r, olast_r, oempty_r, odrop_r;
  logic                       wen_r;
  logic [AW-1:0]              waddr_r;

  logic                       full, is_insert, ins_ok, rm_ok, shifting;
  logic [AW-1:0]              head_dec, ins_addr, rd_addr, cur_addr;
  logic [CW-1:0]              cnt_m1, rd_idx;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd,
                                         input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(hd) + (CW+1)'(l);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign full      = (count_r == CW'(DEPTH));
  assign is_insert = (in_func == olid_pkg::FUNC_FRONT) || (in_func == olid_pkg::FUNC_BACK);
  assign ins_ok    = is_insert && !full;
  assign rm_ok     = !is_insert && (32'(in_position) < 32'(count_r));
  assign head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign ins_addr  = (in_func == olid_pkg::FUNC_FRONT) ? head_dec : phys(head_r, count_r);
  assign cnt_m1    = count_r - CW'(1);

  // past the removed slot, read one ahead and write it back one lower
  assign shifting  = rm_r && (32'(idx_r) >= 32'(pos_r));
  assign rd_idx    = shifting ? idx_r + CW'(1) : idx_r;
  assign rd_addr   = phys(head_r, rd_idx);
  assign cur_addr  = phys(head_r, idx_r);

  assign sts.cnt_zero = (count_r == '0);
  assign sts.at_last  = (idx_r == cnt_m1);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    if (cmd.accept) begin
      idx_nxt = '0;
      if (ins_ok) begin
        count_nxt = count_r + CW'(1);
        if (in_func == olid_pkg::FUNC_FRONT) begin
          head_nxt = head_dec;
        end
      end else if (rm_ok) begin
        count_nxt = cnt_m1;
      end
    end else if (cmd.step) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      idx_r   <= '0;
      ov_r    <= 1'b0;
      wen_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= cmd.step || cmd.emit_empty;
      wen_r   <= cmd.step && shifting;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_r  <= in_position;
      rm_r   <= rm_ok;
      drop_r <= is_insert && full;
    end
    if (cmd.step || cmd.emit_empty) begin
      olast_r  <= cmd.emit_empty || sts.at_last;
      oempty_r <= cmd.emit_empty;
      odrop_r  <= drop_r;
    end
    waddr_r <= cur_addr;
  end

  // single write port: insert at accept, or shift write-back from the registered read data and address
  always_ff @(posedge clk) begin
    if (cmd.accept && ins_ok) begin
      mem[ins_addr] <= in_value;
    end else if (wen_r) begin
      mem[waddr_r] <= rd_r;
    end
    if (cmd.step) begin
      rd_r <= mem[rd_addr];
    end else if (cmd.emit_empty) begin
      rd_r <= '0;
    end
  end

  assign out_valid     = ov_r;
  assign out_element   = rd_r;
  assign out_last      = olast_r;
  assign out_empty_res = oempty_r;
  assign out_dropped   = odrop_r;

  `OLID_ASSERT_NEVER(a_wr_conflict, clk, rst_n, cmd.accept && wen_r, "write port conflict")
  `OLID_ASSERT_NEVER(a_count_range, clk, rst_n, count_r > CW'(DEPTH), "count above depth")
  `OLID_ASSERT_NEVER(a_head_range, clk, rst_n, 32'(head_r) >= DEPTH, "head out of range")
  `OLID_ASSERT_NEXT(a_last_gap, clk, rst_n, ov_r && olast_r, !ov_r, "beat right after last")

endmodule

/* sv/ordered_list_insert_delete_core.sv */
// Ordered list core: insert at front, append at back, remove at position.
// Flow: a request is accepted in idle, then the list is emitted one beat per
// cycle out of the single read port of the element memory (one empty-result
// beat for an empty list), then a write-back state ends a non-empty listing.
// Reset (rst_n low, synchronous) empties the list; element storage is not
// cleared. out_valid strobes each beat for one cycle; no stall is possible.
module ordered_list_insert_delete_core #(
  parameter int DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [olid_pkg::FUNC_W-1:0]       in_func,
  input  logic signed [olid_pkg::DATA_W-1:0] in_value,
  input  logic [olid_pkg::POS_W-1:0]        in_position,
  output logic                              out_valid,
  output logic signed [olid_pkg::DATA_W-1:0] out_element,
  output logic                              out_last,
  output logic                              out_empty_res,
  output logic                              out_dropped
);

  olid_pkg::cmd_t cmd;
  olid_pkg::sts_t sts;

  olid_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  olid_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_func),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_element   (out_element),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .out_dropped   (out_dropped)
  );

endmodule
